// File: design/ihq_pkg.sv
// Package with the entry type and the action and status codes of the indexed min-heap queue.
package ihq_pkg;

    localparam int ID_W   = 8;
    localparam int DIST_W = 31;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef logic [1:0] status_t;

    localparam logic    ACT_INSERT = 1'b0;
    localparam logic    ACT_REMOVE = 1'b1;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

// File: design/ihq_ram.sv
// Heap slot memory with one write port and two registered read ports.
module ihq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 39
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: design/indexed_min_heap_queue.sv
// Top level of the indexed binary min-heap queue with its sift sequencer and slot map.
//
//   Channel  Direction  tdata (low bit first)                      tuser
//   s_axis   in         node_id[7:0], distance[38:8], pad[39]      action
//   m_axis   out        min_node[7:0], min_distance[38:8],         status
//                       now_empty[39]
//
// One word is processed at a time. An insert is accepted, rises level by level, has the word
// placed in its slot and posts the result; a remove is accepted, fetches root and last slot,
// sinks level by level with the word placed where it stops, and posts the result.
// The pace is set by the single write port of the heap memory, one slot written a cycle.
// Reset empties the heap at once; no memory sweep is needed.
// A result waiting on m_axis_tready holds the sequencer in its report state.
module indexed_min_heap_queue #(
    parameter int CAPACITY   = 256,
    parameter int NODE_COUNT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,   // node_id, distance, zero pad
    input  logic                s_axis_tuser,   // action
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // min_node, min_distance, now_empty
    output ihq_pkg::status_t    m_axis_tuser    // status
);

    import ihq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 2;
    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int EW = $bits(entry_t);
    localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_UP,
        S_PLACE,
        S_DOWN,
        S_REPORT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   hole_reg, hole_next;
    entry_t          item_reg, item_next;
    status_t         res_status_reg, res_status_next;
    entry_t          res_entry_reg, res_entry_next;
    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    entry_t          out_entry_reg, out_entry_next;
    logic            out_empty_reg, out_empty_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    entry_t          mem_wdata;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    logic [EW-1:0]   rdata_a;
    logic [EW-1:0]   rdata_b;
    entry_t          rd_a;
    entry_t          rd_b;

    logic            s_accept;
    entry_t          in_entry;
    logic [AW-1:0]   parent;
    logic [SW-1:0]   left_w;
    logic [SW-1:0]   right_w;
    logic [SW-1:0]   count_w;
    logic            pick_right;
    entry_t          pick_e;
    logic [AW-1:0]   pick_slot;

    logic [16:0]     map_id;
    logic            map_we;
    logic [AW-1:0]   map_mem [NODE_COUNT];

    ihq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (EW)
    ) u_heap (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign rd_a     = entry_t'(rdata_a);
    assign rd_b     = entry_t'(rdata_b);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign in_entry = '{distance: s_axis_tdata[38:8], id: s_axis_tdata[7:0]};

    assign parent     = AW'((hole_reg - 1'b1) >> 1);
    assign left_w     = SW'({hole_reg, 1'b1});
    assign right_w    = left_w + 1'b1;
    assign count_w    = SW'(count_reg);
    assign pick_right = (right_w < count_w) && (rd_b.distance < rd_a.distance);
    assign pick_e     = pick_right ? rd_b : rd_a;
    assign pick_slot  = pick_right ? AW'(right_w) : AW'(left_w);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        hole_next       = hole_reg;
        item_next       = item_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_empty_next  = out_empty_reg;
        mem_we          = 1'b0;
        mem_waddr       = hole_reg;
        mem_wdata       = item_reg;
        raddr_a         = parent;
        raddr_b         = parent;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    res_status_next = ST_OK;
                    res_entry_next  = '0;
                    if (s_axis_tuser == ACT_INSERT)
                    begin
                        if (count_reg == CAP_CW)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_REPORT;
                        end
                        else
                        begin
                            item_next  = in_entry;
                            hole_next  = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = in_entry;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                raddr_a    = AW'((AW'(count_reg) - 1'b1) >> 1);
                                state_next = S_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_REPORT;
                        end
                        else
                        begin
                            raddr_a    = '0;
                            raddr_b    = AW'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_POP:
            begin
                res_entry_next = rd_a;
                if (count_reg == '0)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    item_next  = rd_b;
                    hole_next  = '0;
                    raddr_a    = AW'(1);
                    raddr_b    = AW'(2);
                    state_next = S_DOWN;
                end
            end

            S_UP:
            begin
                mem_we = 1'b1;
                if (item_reg.distance < rd_a.distance)
                begin
                    mem_wdata = rd_a;
                    hole_next = parent;
                    raddr_a   = AW'((parent - 1'b1) >> 1);
                    if (parent == '0)
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_PLACE:
            begin
                mem_we     = 1'b1;
                state_next = S_REPORT;
            end

            S_DOWN:
            begin
                mem_we = 1'b1;
                if ((left_w < count_w) && (pick_e.distance < item_reg.distance))
                begin
                    mem_wdata = pick_e;
                    hole_next = pick_slot;
                    raddr_a   = AW'({pick_slot, 1'b1});
                    raddr_b   = AW'({pick_slot, 1'b1}) + 1'b1;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_REPORT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_entry_next  = res_entry_reg;
                    out_empty_next  = (count_reg == '0);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg       <= hole_next;
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_empty_reg  <= out_empty_next;
    end

    // Every heap write places an entry in its new slot, so the map follows each one whose id is below NODE_COUNT.
    assign map_id = 17'(mem_wdata.id);
    assign map_we = mem_we && (map_id < 17'(NODE_COUNT));

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_id[NW-1:0]] <= mem_waddr;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_empty_reg, out_entry_reg.distance, out_entry_reg.id};
    assign m_axis_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CW)
        else $error("entry count exceeds capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (SW'(mem_waddr) < SW'(count_next)))
        else $error("heap write outside the occupied slots");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !s_accept |=> $stable(count_reg))
        else $error("entry count changed without an accepted word");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |-> m_axis_tdata[39])
        else $error("remove on empty heap reported a nonempty heap");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the indexed min-heap queue with stream stimulus and heap predictor.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ihq_pkg::*;

    localparam int CAPACITY = 256;
    localparam int NODE_COUNT = 256;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic              act;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } heap_word_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   node;
        logic [DIST_W-1:0] distance;
        logic              empty;
    } heap_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    status_t     m_axis_tuser;

    heap_word_t   queued_words[$];
    heap_result_t due_results[$];

    entry_t heap_mem[CAPACITY];
    int     heap_len = 0;
    int     shadow_len = 0;
    int     calm_left[2] = '{0, 0};
    int     send_gap = 0;
    int     stall_left = 0;
    int     mismatches = 0;
    int     results_seen = 0;
    int     gap_now;
    int     stall_now;
    heap_word_t   next_word;
    heap_result_t want;

    indexed_min_heap_queue #(
        .CAPACITY(CAPACITY),
        .NODE_COUNT(NODE_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void swap_slots(input int a, input int b);
        entry_t t;
        t = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic heap_result_t heap_apply(input heap_word_t w);
        heap_result_t r;
        int slot;
        int up;
        int left;
        int pick;
        logic done;
        r = '0;
        r.status = ST_OK;
        if (w.act == ACT_INSERT)
        begin
            if (heap_len >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                slot = heap_len;
                heap_mem[slot].id = w.id;
                heap_mem[slot].distance = w.distance;
                heap_len++;
                done = 1'b0;
                while (slot > 0 && !done)
                begin
                    up = (slot - 1) / 2;
                    if (heap_mem[slot].distance < heap_mem[up].distance)
                    begin
                        swap_slots(slot, up);
                        slot = up;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
        end
        else if (heap_len == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.node = heap_mem[0].id;
            r.distance = heap_mem[0].distance;
            heap_len--;
            if (heap_len > 0)
            begin
                heap_mem[0] = heap_mem[heap_len];
                slot = 0;
                done = 1'b0;
                while (!done)
                begin
                    left = 2 * slot + 1;
                    if (left >= heap_len)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        pick = left;
                        if (left + 1 < heap_len &&
                            heap_mem[left + 1].distance < heap_mem[left].distance)
                            pick = left + 1;
                        if (heap_mem[pick].distance < heap_mem[slot].distance)
                        begin
                            swap_slots(slot, pick);
                            slot = pick;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        r.empty = (heap_len == 0);
        return r;
    endfunction

    // Side 0 is the sender, side 1 the receiver; now and then a side runs a stretch without pauses.
    function automatic int draw_pause(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left[side] = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 5))
            0: return DIST_W'($urandom_range(0, 7));
            1: return DIST_MAX - DIST_W'($urandom_range(0, 3));
            2: return DIST_W'($urandom_range(0, 1000));
            default: return DIST_W'($urandom);
        endcase
    endfunction

    task automatic add_word(input logic act, input logic [ID_W-1:0] id,
                            input logic [DIST_W-1:0] distance);
        heap_word_t w;
        w.act = act;
        w.id = id;
        w.distance = distance;
        queued_words.push_back(w);
        if (act == ACT_INSERT && shadow_len < CAPACITY)
            shadow_len++;
        else if (act == ACT_REMOVE && shadow_len > 0)
            shadow_len--;
    endtask

    task automatic add_random(input int insert_pct);
        if ($urandom_range(1, 100) <= insert_pct)
            add_word(ACT_INSERT, ID_W'($urandom_range(0, 255)), pick_dist());
        else
            add_word(ACT_REMOVE, ID_W'($urandom_range(0, 255)), DIST_W'($urandom));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("result %0d %s: got 0x%0h, expected 0x%0h", results_seen, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (s_axis_tvalid)
            begin
                next_word.act = s_axis_tuser;
                next_word.id = s_axis_tdata[7:0];
                next_word.distance = s_axis_tdata[38:8];
                due_results.push_back(heap_apply(next_word));
                gap_now = draw_pause(0);
            end
            else
            begin
                gap_now = send_gap;
            end
            if (gap_now == 0 && queued_words.size() != 0)
            begin
                next_word = queued_words.pop_front();
                s_axis_tdata <= {1'b0, next_word.distance, next_word.id};
                s_axis_tuser <= next_word.act;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= (gap_now == 0) ? 0 : gap_now - 1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
            begin
                report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = due_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[7:0] !== want.node)
                    report_mismatch("min_node", 32'(m_axis_tdata[7:0]), 32'(want.node));
                if (m_axis_tdata[38:8] !== want.distance)
                    report_mismatch("min_distance", 32'(m_axis_tdata[38:8]),
                                    32'(want.distance));
                if (m_axis_tdata[39] !== want.empty)
                    report_mismatch("now_empty", 32'(m_axis_tdata[39]), 32'(want.empty));
            end
            results_seen++;
            stall_now = draw_pause(1);
            stall_left <= stall_now;
            m_axis_tready <= (stall_now == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        // Directed part: empty remove, field extremes, ties at the root, drain to empty.
        add_word(ACT_REMOVE, 8'hFF, DIST_MAX);
        add_word(ACT_INSERT, 8'h00, DIST_MAX);
        add_word(ACT_INSERT, 8'hFF, '0);
        add_word(ACT_INSERT, 8'h55, 31'h2AAAAAAA);
        add_word(ACT_INSERT, 8'hAA, 31'h55555555);
        add_word(ACT_INSERT, 8'h07, '0);
        add_word(ACT_INSERT, 8'h08, 31'h2AAAAAAA);
        add_word(ACT_INSERT, 8'h09, 31'h2AAAAAAA);
        for (i = 0; i < 8; i++)
            add_word(ACT_REMOVE, 8'hA5, 31'h5A5A5A5A);
        add_word(ACT_INSERT, 8'h3C, 31'd5);
        add_word(ACT_INSERT, 8'hC3, 31'd5);
        add_word(ACT_INSERT, 8'h11, 31'd5);
        add_word(ACT_REMOVE, 8'h00, '0);
        add_word(ACT_REMOVE, 8'h00, '0);
        add_word(ACT_REMOVE, 8'h00, '0);

        for (i = 0; i < 20; i++)
            add_random(60);
        // Fill to capacity, probe the full heap, then remove through deep sift-downs.
        while (shadow_len < CAPACITY)
            add_random(95);
        for (i = 0; i < 3; i++)
            add_word(ACT_INSERT, ID_W'($urandom_range(0, 255)), pick_dist());
        for (i = 0; i < 100; i++)
            add_random(10);

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (queued_words.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("indexed_min_heap_queue regression: pass");
        else
            $display("indexed_min_heap_queue regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("indexed_min_heap_queue regression: fail");
        $finish;
    end

endmodule

// File: sim.f
design/ihq_pkg.sv
design/ihq_ram.sv
design/indexed_min_heap_queue.sv
tb/tb_top.sv
